@@ design/rlfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range-limited float codec package
// Shared constants, register map, derived-setting type and helper functions.
// ----------------------------------------------------------------------------
package rlfc_pkg;

	localparam int unsigned MANT_BITS = 23;
	localparam int unsigned PREC_W    = 5;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned ADDR_W    = 4;

	localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [WORD_W-1:0] ABS_MASK = 32'h7FFF_FFFF;

	localparam logic [WORD_W-1:0] MIN_RESET  = 32'hBF80_0000;
	localparam logic [WORD_W-1:0] EPS_RESET  = 32'h3A80_0000;
	localparam logic [WORD_W-1:0] MAX_RESET  = 32'h3F80_0000;
	localparam logic [PREC_W-1:0] PREC_RESET = 5'd10;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_MIN  = 2'd0,
		REG_EPS  = 2'd1,
		REG_MAX  = 2'd2,
		REG_PREC = 2'd3
	} reg_idx_t;

	// Settings derived from the configuration registers.
	typedef struct packed {
		logic [PREC_W-1:0] shift;
		logic              neg_mode;
		logic              lossless;
		logic [WORD_W-1:0] top_code;
		logic [WORD_W-1:0] zero_code;
		logic [WORD_W-1:0] pos_gap;
		logic [WORD_W-1:0] neg_gap;
	} derived_t;

	// Signed greater-than on raw 32-bit patterns.
	function automatic logic sgt(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

endpackage
`default_nettype wire

@@ design/range_limited_float_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat passes through vld_s1, vld_s2 and vld_s3 before done, which strobes the result for one cycle.
// Throughput: one item per cycle; busy is never raised, the three compute stages
// (clamp and shift or first gap step, negative gap, positive gap or widening) form a plain pipeline.
// Derived settings are registered from the configuration registers in the cycle after a configuration write.
// Reset clears the pipeline valid bits and loads the default register values.
// ----------------------------------------------------------------------------
// Range-limited float codec
// Packs float bit patterns into short codes and unpacks them, with an APB-style
// register port for min, epsilon, max and kept precision.
// ----------------------------------------------------------------------------
module range_limited_float_codec
	import rlfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [WORD_W-1:0] value,
	output logic                   done,
	output logic [WORD_W-1:0]      result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0]      prdata,
	output logic                   pready
);

	logic [WORD_W-1:0] min_q;
	logic [WORD_W-1:0] eps_q;
	logic [WORD_W-1:0] max_q;
	logic [PREC_W-1:0] prec_q;
	derived_t          der_q;
	derived_t          der_d;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	logic              vld_s1, vld_s2, vld_s3;
	logic              op_s1, op_s2, op_s3;
	logic [WORD_W-1:0] val_s1, val_s2, val_s3;

	logic [WORD_W-1:0] stage2_v;
	logic [WORD_W-1:0] stage3_v;
	logic [WORD_W-1:0] stage4_v;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ---------------- configuration port ----------------
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_RESET;
			eps_q  <= EPS_RESET;
			max_q  <= MAX_RESET;
			prec_q <= PREC_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIN:  min_q  <= pwdata;
				REG_EPS:  eps_q  <= pwdata;
				REG_MAX:  max_q  <= pwdata;
				REG_PREC: prec_q <= pwdata[PREC_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MIN:  prdata = min_q;
			REG_EPS:  prdata = eps_q;
			REG_MAX:  prdata = max_q;
			REG_PREC: prdata = {{(WORD_W-PREC_W){1'b0}}, prec_q};
		endcase
	end

	// ---------------- derived settings ----------------
	always_comb begin
		logic [PREC_W-1:0] p;
		logic [WORD_W-1:0] pos_eps;
		logic [WORD_W-1:0] neg_eps;
		p = (prec_q > PREC_W'(MANT_BITS)) ? PREC_W'(MANT_BITS) : prec_q;
		der_d.shift    = PREC_W'(MANT_BITS) - p;
		der_d.neg_mode = min_q[WORD_W-1];
		der_d.lossless = (der_d.shift == '0);
		if (der_d.lossless) begin
			neg_eps         = eps_q;
			pos_eps         = eps_q ^ SIGN_BIT;
			der_d.top_code  = max_q ^ SIGN_BIT;
			der_d.zero_code = SIGN_BIT;
		end else begin
			neg_eps         = (eps_q ^ SIGN_BIT) >> der_d.shift;
			pos_eps         = eps_q >> der_d.shift;
			der_d.top_code  = max_q >> der_d.shift;
			der_d.zero_code = '0;
		end
		der_d.pos_gap = pos_eps - der_d.zero_code - WORD_W'(1);
		der_d.neg_gap = neg_eps - der_d.top_code - WORD_W'(1);
	end

	always_ff @(posedge clk) begin
		der_q <= der_d;
	end

	// ---------------- pipeline valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	// Stage 2: clamp, flush and drop bits when encoding; first gap step when decoding.
	always_comb begin
		logic [WORD_W-1:0] bound;
		logic [WORD_W-1:0] lim;
		logic [WORD_W-1:0] dv;
		bound = (der_q.neg_mode && val_s1[WORD_W-1]) ? min_q : max_q;
		lim   = sgt(val_s1, bound) ? bound : val_s1;
		// Epsilon is compared signed against the non-negative magnitude.
		if (sgt(eps_q, lim & ABS_MASK)) begin
			lim = '0;
		end
		dv = der_q.lossless ? (val_s1 ^ SIGN_BIT) : val_s1;
		if (sgt(dv, der_q.zero_code)) begin
			dv = dv + der_q.pos_gap;
		end
		if (op_s1 == OP_DECODE) begin
			stage2_v = dv;
		end else if (der_q.lossless) begin
			stage2_v = lim ^ SIGN_BIT;
		end else begin
			stage2_v = lim >> der_q.shift;
		end
	end

	// Stage 3: the negative-range gap, removed or restored.
	always_comb begin
		stage3_v = val_s2;
		if (der_q.neg_mode && sgt(val_s2, der_q.top_code)) begin
			stage3_v = (op_s2 == OP_DECODE) ? (val_s2 + der_q.neg_gap)
			                                : (val_s2 - der_q.neg_gap);
		end
	end

	// Stage 4: positive gap when encoding, widening back to a float when decoding.
	always_comb begin
		logic [WORD_W-1:0] ev;
		ev = sgt(val_s3, der_q.zero_code) ? (val_s3 - der_q.pos_gap) : val_s3;
		if (op_s3 == OP_DECODE) begin
			stage4_v = der_q.lossless ? (val_s3 ^ SIGN_BIT) : (val_s3 << der_q.shift);
		end else begin
			stage4_v = der_q.lossless ? (ev ^ SIGN_BIT) : ev;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= opcode;
			val_s1 <= value;
		end
		op_s2  <= op_s1;
		val_s2 <= stage2_v;
		op_s3  <= op_s2;
		val_s3 <= stage3_v;
		result <= stage4_v;
	end

endmodule
`default_nettype wire

@@ design/rlfc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range-limited float codec port checker
// Watches the top-level ports for beat timing and register port behavior.
// ----------------------------------------------------------------------------
module rlfc_checker
	import rlfc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [WORD_W-1:0] pwdata,
	input wire logic [WORD_W-1:0] prdata,
	input wire logic              pready
);

	// Every accepted beat is followed by a done strobe once it has passed vld_s1, vld_s2 and vld_s3.
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted beat produced no result four cycles later");

	// No result appears without a matching beat accepted earlier in the pipeline.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching accepted beat");

	// A written minimum reads back on the next cycle.
	a_min_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (paddr[3:2] == REG_MIN))
		|=> ((paddr[3:2] != REG_MIN) || (prdata == $past(pwdata))))
		else $error("minimum register readback mismatch");

	// The codec never refuses a beat.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind range_limited_float_codec rlfc_checker u_rlfc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);
`default_nettype wire

@@ tb/range_limited_float_codec_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-limited float codec testbench
// Drives encode and decode beats through the command port and moves the four
// registers through several settings over the register port. Every setting is
// read back. A scoreboard class predicts each result from its own copy of the
// registers and checks the strobed results in order.
// ----------------------------------------------------------------------------
module range_limited_float_codec_test;
	import rlfc_pkg::*;

	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_PHASES      = 9;
	localparam int MAX_REPORTS     = 40;

	class codec_scoreboard;
		logic [31:0] min_q;
		logic [31:0] eps_q;
		logic [31:0] max_q;
		logic [4:0]  prec_q;
		logic [31:0] expected_words[$];
		int errors;
		int reports;
		int n_encode;
		int n_decode;
		int n_results;

		function new();
			min_q     = MIN_RESET;
			eps_q     = EPS_RESET;
			max_q     = MAX_RESET;
			prec_q    = PREC_RESET;
			errors    = 0;
			reports   = 0;
			n_encode  = 0;
			n_decode  = 0;
			n_results = 0;
		endfunction

		static function logic above(logic [31:0] a, logic [31:0] b);
			return (a ^ SIGN_BIT) > (b ^ SIGN_BIT);
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_MIN:  min_q = data;
				REG_EPS:  eps_q = data;
				REG_MAX:  max_q = data;
				REG_PREC: prec_q = data[4:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_MIN:  return min_q;
				REG_EPS:  return eps_q;
				REG_MAX:  return max_q;
				default:  return {27'd0, prec_q};
			endcase
		endfunction

		function void mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("%0t: %s mismatch: expected %08h, actual %08h", $time, what,
					exp_v, act_v);
			end
		endfunction

		function logic [31:0] codec_word(logic op, logic [31:0] x);
			logic [4:0]  kept;
			logic [4:0]  sh;
			logic        neg_mode;
			logic        lossless;
			logic [31:0] top;
			logic [31:0] zero;
			logic [31:0] pos_eps;
			logic [31:0] neg_eps;
			logic [31:0] pos_gap;
			logic [31:0] neg_gap;
			logic [31:0] bound;
			logic [31:0] v;
			kept     = (prec_q > 5'd23) ? 5'd23 : prec_q;
			sh       = 5'd23 - kept;
			neg_mode = min_q[31];
			lossless = (sh == 5'd0);
			// With all mantissa bits kept the code lives in offset-binary form.
			if (lossless) begin
				neg_eps = eps_q;
				pos_eps = eps_q ^ SIGN_BIT;
				top     = max_q ^ SIGN_BIT;
				zero    = SIGN_BIT;
			end else begin
				neg_eps = (eps_q ^ SIGN_BIT) >> sh;
				pos_eps = eps_q >> sh;
				top     = max_q >> sh;
				zero    = 32'd0;
			end
			pos_gap = pos_eps - zero - 32'd1;
			neg_gap = neg_eps - top - 32'd1;
			v = x;
			if (op == OP_ENCODE) begin
				bound = (neg_mode && v[31]) ? min_q : max_q;
				if (above(v, bound))
					v = bound;
				if (above(eps_q, v & ABS_MASK))
					v = 32'd0;
				v = lossless ? (v ^ SIGN_BIT) : (v >> sh);
				if (neg_mode && above(v, top))
					v = v - neg_gap;
				if (above(v, zero))
					v = v - pos_gap;
				if (lossless)
					v = v ^ SIGN_BIT;
			end else begin
				if (lossless)
					v = v ^ SIGN_BIT;
				if (above(v, zero))
					v = v + pos_gap;
				if (neg_mode && above(v, top))
					v = v + neg_gap;
				v = lossless ? (v ^ SIGN_BIT) : (v << sh);
			end
			return v;
		endfunction

		function void note_input(logic op, logic [31:0] x);
			if (op == OP_ENCODE)
				n_encode++;
			else
				n_decode++;
			expected_words.push_back(codec_word(op, x));
		endfunction

		function void check_result(logic [31:0] act_v);
			logic [31:0] exp_v;
			n_results++;
			if (expected_words.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: result with nothing expected: expected none, actual %08h",
						$time, act_v);
				end
			end else begin
				exp_v = expected_words.pop_front();
				if (act_v !== exp_v)
					mismatch("result", exp_v, act_v);
			end
		endfunction
	endclass

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        opcode  = OP_ENCODE;
	logic [31:0] value   = 32'd0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = 4'd0;
	logic [31:0] pwdata  = 32'd0;
	wire         busy;
	wire         done;
	wire  [31:0] result;
	wire  [31:0] prdata;
	wire         pready;

	codec_scoreboard sb;
	int          n_settings = 0;

	range_limited_float_codec u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.opcode  (opcode),
		.value   (value),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Observes beats at each edge, before any driven value of that edge lands.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if ($isunknown(done))
				sb.mismatch("done strobe", 32'd0, {31'd0, done});
			else if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_input(opcode, value);
			if (psel && penable && pwrite && pready)
				sb.write_reg(reg_idx_t'(paddr[3:2]), pwdata);
		end
	end

	task automatic drive_item(input logic op, input logic [31:0] x);
		start  <= 1'b1;
		opcode <= op;
		value  <= x;
		do @(posedge clk); while (busy);
	endtask

	// Start stays low for the whole burst; the payload carries noise meanwhile.
	task automatic idle_burst(input int n);
		start  <= 1'b0;
		opcode <= 1'($urandom);
		value  <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	// The first edge lets the last accepted beat reach the scoreboard queue.
	task automatic wait_drained();
		do @(posedge clk); while (sb.expected_words.size() != 0);
	endtask

	// psel stays high between back-to-back transfers; apb_release ends the run of them.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_read(input reg_idx_t idx);
		logic [31:0] exp_v;
		logic [31:0] act_v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		exp_v = sb.reg_value(idx);
		act_v = prdata;
		if (idx == REG_PREC)
			act_v = {27'd0, act_v[4:0]};
		if (act_v !== exp_v)
			sb.mismatch("register read", exp_v, act_v);
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all();
		apb_read(REG_MIN);
		apb_read(REG_EPS);
		apb_read(REG_MAX);
		apb_read(REG_PREC);
	endtask

	task automatic configure(input logic [31:0] mn, input logic [31:0] ep,
			input logic [31:0] mx, input logic [31:0] pr_word);
		wait_drained();
		apb_write(REG_MIN, mn);
		apb_write(REG_EPS, ep);
		apb_write(REG_MAX, mx);
		apb_write(REG_PREC, pr_word);
		// The read-back also gives the registered derived settings time to settle.
		read_all();
		apb_release();
		n_settings++;
	endtask

	function automatic logic [31:0] jitter();
		return 32'($urandom_range(0, 6)) - 32'd3;
	endfunction

	// Float patterns weighted toward the clamp and flush boundaries.
	function automatic logic [31:0] pick_float();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] w;
		lo = sb.eps_q & ABS_MASK;
		hi = sb.max_q & ABS_MASK;
		case ($urandom_range(0, 9)) inside
			0, 1: w = $urandom;
			2:    w = sb.max_q + jitter();
			3:    w = sb.min_q + jitter();
			4:    w = {1'($urandom), sb.eps_q[30:0]} + jitter();
			5:    w = {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
			6:    w = {1'($urandom), 29'd0, 2'($urandom)};
			default: begin
				if (hi > lo)
					w = lo + ($urandom % (hi - lo + 32'd1));
				else
					w = $urandom;
				w[31] = 1'($urandom);
			end
		endcase
		return w;
	endfunction

	task automatic random_item();
		logic [31:0] x;
		if ($urandom_range(0, 1) == 0) begin
			drive_item(OP_ENCODE, pick_float());
		end else begin
			case ($urandom_range(0, 9)) inside
				7, 8: x = $urandom;
				9:    x = 32'($urandom_range(0, 64));
				default: x = sb.codec_word(OP_ENCODE, pick_float()) + jitter();
			endcase
			drive_item(OP_DECODE, x);
		end
	endtask

	task automatic directed_items();
		logic [31:0] floats[$];
		floats = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F80_0000,
			32'h7FFF_FFFF, 32'hBF80_0000, 32'hFF80_0000, 32'hFFFF_FFFF,
			32'h3A80_0000, 32'h3A7F_FFFF, 32'hBA80_0000, 32'hBA7F_FFFF,
			32'h3F00_0000, 32'hBF00_0000, 32'h7FC0_0000};
		foreach (floats[i])
			drive_item(OP_ENCODE, floats[i]);
		drive_item(OP_DECODE, 32'h0000_0000);
		drive_item(OP_DECODE, 32'h0000_0001);
		drive_item(OP_DECODE, sb.codec_word(OP_ENCODE, 32'h3F80_0000));
		drive_item(OP_DECODE, sb.codec_word(OP_ENCODE, 32'hBF80_0000));
		drive_item(OP_DECODE, 32'hFFFF_FFFF);
		drive_item(OP_DECODE, 32'h8000_0000);
		drive_item(OP_DECODE, 32'h7FFF_FFFF);
		start <= 1'b0;
	endtask

	task automatic phase_setting(input int ph);
		case (ph)
			0: configure(MIN_RESET, EPS_RESET, MAX_RESET, 32'd23);
			1: configure(MIN_RESET, EPS_RESET, MAX_RESET, 32'd0);
			// Negatives mode off.
			2: configure(32'h0000_0000, 32'h3C00_0000, 32'h4700_0000, 32'd16);
			3: configure(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'd31);
			// Register ordering broken; upper bits of the precision word are junk.
			4: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
			5: configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
			default: configure(
				($urandom_range(0, 3) == 0) ? 32'd0 :
					{1'b1, 8'($urandom_range(100, 140)), 23'($urandom)},
				{1'b0, 8'($urandom_range(90, 125)), 23'($urandom)},
				{1'b0, 8'($urandom_range(120, 160)), 23'($urandom)},
				{27'($urandom), 5'($urandom_range(0, 23))});
		endcase
	endtask

	initial begin
		int idle_pct;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all();
		apb_release();
		directed_items();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			phase_setting(ph);
			// The final phase, and every third one, runs back to back.
			if (ph == NUM_PHASES - 1 || ph % 3 == 1)
				idle_pct = 0;
			else
				idle_pct = 30;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					idle_burst($urandom_range(1, 4));
				random_item();
			end
			start <= 1'b0;
		end
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Ran %0d encode and %0d decode beats, %0d results, over %0d register settings.",
			sb.n_encode, sb.n_decode, sb.n_results, n_settings + 1);
		$display("Settings covered lossless, coarsest, negatives-off and out-of-order registers.");
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("range_limited_float_codec_test OK");
		end else begin
			$display("range_limited_float_codec_test NOT OK");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d results outstanding", $time,
			sb.expected_words.size());
		$display("range_limited_float_codec_test NOT OK");
		$finish;
	end

endmodule
